@@ sv/xorshift96_random_modulo_core_macros.svh @@
// Assertion helpers shared by the generator's modules.
// Both expect clk and rst_n in scope.
`ifndef XORSHIFT96_RANDOM_MODULO_CORE_MACROS_SVH
`define XORSHIFT96_RANDOM_MODULO_CORE_MACROS_SVH

// Same-cycle implication.
`define XRM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define XRM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/xrm_pkg.sv @@
package xrm_pkg;

    localparam int WORD_W  = 64;
    localparam int LIMIT_W = 32;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int IDX_W   = 2;

    localparam logic [WORD_W-1:0] SEED_FIRST_RST  = WORD_W'(64'd123456789);
    localparam logic [WORD_W-1:0] SEED_SECOND_RST = WORD_W'(64'd362436069);
    localparam logic [WORD_W-1:0] SEED_THIRD_RST  = WORD_W'(64'd521288629);

    localparam int SHIFT_A = 16;
    localparam int SHIFT_B = 5;
    localparam int SHIFT_C = 1;

    localparam logic [IDX_W-1:0] CFG_SEED_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_SEED_SECOND = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_SEED_THIRD  = IDX_W'(2);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    // Per-cycle control broadcast to every remainder cell.
    typedef struct packed {
        logic load;
        logic step;
        logic sub;
    } cell_ctrl_t;

    // Request into the remainder row.
    typedef struct packed {
        logic               load;
        logic [LIMIT_W-1:0] limit;
        logic [WORD_W-1:0]  dividend;
    } rem_ctrl_t;

    // Status back from the remainder row.
    typedef struct packed {
        logic               busy;
        logic [LIMIT_W-1:0] remainder;
    } rem_stat_t;

endpackage

@@ sv/xorshift96_random_modulo_core.sv @@
// An accepted request runs through the remainder row; its result then loads into the output register.
// The 64 remainder steps of the cell row bound throughput; a new request waits for the result to load.
// Word advance takes place at the accept edge; the row then shifts one dividend bit per cycle.
// Reset: words load the default seeds, output holds no transaction, no clearing pass.
// Seed writes load the matching word at once and are taken at any edge.
`include "xorshift96_random_modulo_core_macros.svh"

module xorshift96_random_modulo_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [xrm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [xrm_pkg::WORD_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [xrm_pkg::LIMIT_W-1:0] limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [xrm_pkg::LIMIT_W-1:0] value,
    output logic                        limit_error
);

    import xrm_pkg::*;

    // Generator words.
    logic [WORD_W-1:0]  w1_reg;
    logic [WORD_W-1:0]  w1_next;
    logic [WORD_W-1:0]  w2_reg;
    logic [WORD_W-1:0]  w2_next;
    logic [WORD_W-1:0]  w3_reg;
    logic [WORD_W-1:0]  w3_next;
    logic [WORD_W-1:0]  mix_a;
    logic [WORD_W-1:0]  mix_b;
    logic [WORD_W-1:0]  mix_c;
    logic [WORD_W-1:0]  new_third;

    // Control and result holding.
    state_t             state_reg;
    state_t             state_next;
    logic               err_reg;
    logic               err_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [LIMIT_W-1:0] value_reg;
    logic [LIMIT_W-1:0] value_next;
    logic               lim_err_reg;
    logic               lim_err_next;

    logic               accept;
    logic               out_load;
    rem_ctrl_t          row_ctrl;
    rem_stat_t          row_stat;

    assign accept = in_valid && in_ready;

    // Xorshift advance: shifts 16, 5 and 1 on the first word, mix in the other two.
    always_comb
    begin
        mix_a     = w1_reg ^ (w1_reg << SHIFT_A);
        mix_b     = mix_a ^ (mix_a >> SHIFT_B);
        mix_c     = mix_b ^ (mix_b << SHIFT_C);
        new_third = mix_c ^ w2_reg ^ w3_reg;
    end

    // Advance the words on accept; a seed write overrides its word.
    always_comb
    begin
        w1_next = w1_reg;
        w2_next = w2_reg;
        w3_next = w3_reg;
        if (accept)
        begin
            w1_next = w2_reg;
            w2_next = w3_reg;
            w3_next = new_third;
        end
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_SEED_FIRST:  w1_next = cfg_data;
                CFG_SEED_SECOND: w2_next = cfg_data;
                CFG_SEED_THIRD:  w3_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg <= SEED_FIRST_RST;
            w2_reg <= SEED_SECOND_RST;
            w3_reg <= SEED_THIRD_RST;
        end
        else
        begin
            w1_reg <= w1_next;
            w2_reg <= w2_next;
            w3_reg <= w3_next;
        end
    end

    // Feed the freshly advanced word straight into the remainder row.
    assign row_ctrl.load     = accept;
    assign row_ctrl.limit    = limit;
    assign row_ctrl.dividend = new_third;

    xrm_rem_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (row_ctrl),
        .stat  (row_stat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_CALC: out_load = !row_stat.busy && (!out_valid_reg || out_ready);
            default: ;
        endcase
    end

    // Hold the zero-limit flag; drop the remainder in favor of zero when it is set.
    always_comb
    begin
        err_next       = accept ? (limit == '0) : err_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        lim_err_next   = lim_err_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = err_reg ? '0 : row_stat.remainder;
            lim_err_next   = err_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        value_reg   <= value_next;
        lim_err_reg <= lim_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign limit_error = lim_err_reg;

    `XRM_ASSERT_NXT(a_accept_busy, accept, row_stat.busy && state_reg == ST_CALC, "accepted transaction did not start the row")
    `XRM_ASSERT_IMP(a_err_zero, out_valid_reg && lim_err_reg, value_reg == '0, "error result carries a nonzero value")
    `XRM_ASSERT_NXT(a_load_valid, out_load, out_valid_reg, "finished result not presented")
    `XRM_ASSERT_IMP(a_no_load_busy, row_stat.busy, !out_load && !in_ready, "result taken while the row still works")

endmodule

@@ sv/xrm_cell.sv @@
module xrm_cell (
    input  logic              clk,
    input  xrm_pkg::cell_ctrl_t ctrl,
    input  logic              limit_bit,
    input  logic              shift_in,
    input  logic              borrow_in,
    output logic              rem_bit,
    output logic              borrow_out
);

    logic rem_reg;
    logic rem_next;
    logic lim_reg;
    logic lim_next;
    logic diff;

    // One bit slice of the trial subtraction on the shifted remainder.
    always_comb
    begin
        diff       = shift_in ^ lim_reg ^ borrow_in;
        borrow_out = (~shift_in & lim_reg) | (~(shift_in ^ lim_reg) & borrow_in);
        rem_next   = rem_reg;
        lim_next   = lim_reg;
        if (ctrl.load)
        begin
            rem_next = 1'b0;
            lim_next = limit_bit;
        end
        else if (ctrl.step)
        begin
            rem_next = ctrl.sub ? diff : shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lim_reg <= lim_next;
    end

    assign rem_bit = rem_reg;

endmodule

@@ sv/xrm_rem_row.sv @@
`include "xorshift96_random_modulo_core_macros.svh"

module xrm_rem_row (
    input  logic               clk,
    input  logic               rst_n,
    input  xrm_pkg::rem_ctrl_t ctrl,
    output xrm_pkg::rem_stat_t stat
);

    import xrm_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic [WORD_W-1:0]  dvd_reg;
    logic [WORD_W-1:0]  dvd_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;

    logic [LIMIT_W-1:0] rem_bits;
    logic [LIMIT_W-1:0] shift_bits;
    logic [LIMIT_W:0]   borrow;
    cell_ctrl_t         cell_ctrl;

    // Shift chain: dividend MSB enters the bottom cell, each cell feeds the next.
    assign shift_bits = {rem_bits[LIMIT_W-2:0], dvd_reg[WORD_W-1]};
    assign borrow[0]  = 1'b0;

    // Subtract when the bit leaving the top or a borrow-free compare says S >= limit.
    assign cell_ctrl.load = ctrl.load;
    assign cell_ctrl.step = busy_reg;
    assign cell_ctrl.sub  = rem_bits[LIMIT_W-1] | ~borrow[LIMIT_W];

    for (genvar i = 0; i < LIMIT_W; i++)
    begin : g_cell
        xrm_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .limit_bit  (ctrl.limit[i]),
            .shift_in   (shift_bits[i]),
            .borrow_in  (borrow[i]),
            .rem_bit    (rem_bits[i]),
            .borrow_out (borrow[i+1])
        );
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.load)
        begin
            dvd_next  = ctrl.dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.remainder = rem_bits;

    `XRM_ASSERT_NXT(a_load_starts, ctrl.load, busy_reg && cnt_reg == '0, "load did not start the row")
    `XRM_ASSERT_NXT(a_last_step_ends, busy_reg && cnt_reg == CNT_LAST && !ctrl.load, !busy_reg, "row ran past the last step")
    `XRM_ASSERT_NXT(a_idle_holds_count, !busy_reg && !ctrl.load, $stable(cnt_reg), "count moved while idle")

endmodule
